// ===== hw/rtl/hcr_pkg.sv =====
// hcr_pkg: shared types and constants for the heat/cool on/off regulator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package hcr_pkg;

    localparam int unsigned VAL_W   = 16;
    localparam int unsigned BAND_W  = 15;
    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned FAIL_W  = 8;
    localparam int unsigned CFG_DW  = 16;
    localparam int unsigned CFG_IW  = 3;

    localparam logic [FAIL_W-1:0] FAIL_LIMIT_RST = 8'd3;
    localparam logic [FAIL_W-1:0] FAIL_CNT_MAX   = 8'd255;

    // command carried with each input transaction
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_ENABLE  = 2'd1,
        CMD_DISABLE = 2'd2,
        CMD_OFF     = 2'd3
    } t_cmd;

    // regulator run state
    typedef enum logic [1:0] {
        RUN_OFF  = 2'd0,
        RUN_INIT = 2'd1,
        RUN_BUSY = 2'd2
    } t_run;

    // active actuator
    typedef enum logic [1:0] {
        SIDE_HEATER = 2'd0,
        SIDE_COOLER = 2'd1,
        SIDE_NONE   = 2'd2
    } t_side;

    // configuration register indexes
    typedef enum logic [CFG_IW-1:0] {
        CFG_GOAL         = 3'd0,
        CFG_HEATER_BAND  = 3'd1,
        CFG_COOLER_BAND  = 3'd2,
        CFG_SWAP_DELAY   = 3'd3,
        CFG_HEATER_LEVEL = 3'd4,
        CFG_COOLER_LEVEL = 3'd5,
        CFG_FAIL_LIMIT   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [VAL_W-1:0] goal;
        logic [BAND_W-1:0]       heater_band;
        logic [BAND_W-1:0]       cooler_band;
        logic [VAL_W-1:0]        swap_delay;
        logic [LEVEL_W-1:0]      heater_level;
        logic [LEVEL_W-1:0]      cooler_level;
        logic [FAIL_W-1:0]       fail_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]              mode;
        logic                    reading_ok;
        logic signed [VAL_W-1:0] reading;
    } t_item;

    typedef struct packed {
        logic                 driving;
        t_side                active_side;
        t_run                 run_state;
        logic [LEVEL_W-1:0]   cooler_drive;
        logic [LEVEL_W-1:0]   heater_drive;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/hcr_cfg_regs.sv =====
// hcr_cfg_regs: configuration register file, write only
// depends on hcr_pkg
`timescale 1ns / 1ps
`default_nettype none

module hcr_cfg_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_we,
    input  wire logic [hcr_pkg::CFG_IW-1:0] i_idx,
    input  wire logic [hcr_pkg::CFG_DW-1:0] i_data,
    output hcr_pkg::t_cfg                   o_cfg
);
    import hcr_pkg::*;

    t_cfg r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.goal         <= '0;
            r_cfg.heater_band  <= '0;
            r_cfg.cooler_band  <= '0;
            r_cfg.swap_delay   <= '0;
            r_cfg.heater_level <= '0;
            r_cfg.cooler_level <= '0;
            r_cfg.fail_limit   <= FAIL_LIMIT_RST;
        end else if (i_we) begin
            unique case (i_idx)
                CFG_GOAL:         r_cfg.goal         <= i_data;
                CFG_HEATER_BAND:  r_cfg.heater_band  <= i_data[BAND_W-1:0];
                CFG_COOLER_BAND:  r_cfg.cooler_band  <= i_data[BAND_W-1:0];
                CFG_SWAP_DELAY:   r_cfg.swap_delay   <= i_data;
                CFG_HEATER_LEVEL: r_cfg.heater_level <= i_data;
                CFG_COOLER_LEVEL: r_cfg.cooler_level <= i_data;
                CFG_FAIL_LIMIT:   r_cfg.fail_limit   <= i_data[FAIL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hw/rtl/hcr_in_stage.sv =====
// hcr_in_stage: input register holding one command transaction
// depends on hcr_pkg
`timescale 1ns / 1ps
`default_nettype none

module hcr_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  hcr_pkg::t_item     i_item,
    output logic               o_valid,
    input  wire logic          i_take,
    output hcr_pkg::t_item     o_item
);
    import hcr_pkg::*;

    logic  r_valid;
    t_item r_item;

    // free when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== hw/rtl/hcr_core.sv =====
// hcr_core: regulator state registers and next-state logic
// depends on hcr_pkg; one command is applied per cycle when i_en is high
`timescale 1ns / 1ps
`default_nettype none

module hcr_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  hcr_pkg::t_item   i_item,
    input  hcr_pkg::t_cfg    i_cfg,
    output hcr_pkg::t_result o_result
);
    import hcr_pkg::*;

    localparam int unsigned SUM_W = VAL_W + 2;

    t_run               r_run,       n_run;
    t_side              r_side,      n_side;
    logic               r_phase,     n_phase;
    logic [VAL_W-1:0]   r_out_ticks, n_out_ticks;
    logic [FAIL_W-1:0]  r_fail_cnt,  n_fail_cnt;
    logic [LEVEL_W-1:0] r_heat_out,  n_heat_out;
    logic [LEVEL_W-1:0] r_cool_out,  n_cool_out;

    logic signed [SUM_W-1:0] goal_x, rd_x;
    logic signed [SUM_W-1:0] heat_hi, heat_lo, cool_hi, cool_lo;
    logic above_heat, below_heat, above_cool, below_cool;
    logic was_cool, now_cool, out_band, swap;

    // band limits at 18 bits so sums cannot wrap
    always_comb begin
        goal_x  = SUM_W'(i_cfg.goal);
        rd_x    = SUM_W'(i_item.reading);
        heat_hi = goal_x + $signed({3'b000, i_cfg.heater_band});
        heat_lo = goal_x - $signed({3'b000, i_cfg.heater_band});
        cool_hi = goal_x + $signed({3'b000, i_cfg.cooler_band});
        cool_lo = goal_x - $signed({3'b000, i_cfg.cooler_band});
        above_heat = rd_x > heat_hi;
        below_heat = rd_x < heat_lo;
        above_cool = rd_x > cool_hi;
        below_cool = rd_x < cool_lo;
    end

    // out-of-band test and swap decision for a busy tick
    always_comb begin
        was_cool = (r_side == SIDE_COOLER);
        out_band = was_cool ? below_cool : above_heat;
        swap     = out_band && (r_out_ticks >= i_cfg.swap_delay);
        now_cool = was_cool ^ swap;
    end

    // next state
    always_comb begin
        n_run       = r_run;
        n_side      = r_side;
        n_phase     = r_phase;
        n_out_ticks = r_out_ticks;
        n_fail_cnt  = r_fail_cnt;
        n_heat_out  = r_heat_out;
        n_cool_out  = r_cool_out;
        unique case (t_cmd'(i_item.mode))
            CMD_ENABLE: begin
                n_run = RUN_INIT;
            end
            CMD_DISABLE: begin
                n_heat_out  = '0;
                n_cool_out  = '0;
                n_out_ticks = '0;
                n_side      = SIDE_NONE;
                n_phase     = 1'b0;
                n_run       = RUN_OFF;
            end
            CMD_OFF: begin
                n_run      = RUN_OFF;
                n_heat_out = '0;
                n_cool_out = '0;
            end
            CMD_TICK: begin
                unique case (r_run)
                    RUN_INIT: begin
                        n_out_ticks = '0;
                        n_heat_out  = '0;
                        n_cool_out  = '0;
                        n_fail_cnt  = '0;
                        n_phase     = 1'b0;
                        n_side      = SIDE_HEATER;
                        if (i_item.reading_ok) begin
                            if (rd_x > goal_x) begin
                                n_side = SIDE_COOLER;
                            end
                            n_run = RUN_BUSY;
                        end
                    end
                    RUN_BUSY: begin
                        if (i_item.reading_ok) begin
                            n_fail_cnt = '0;
                            // dwell counter restarts on swap or return to band
                            if (swap || !out_band) begin
                                n_out_ticks = '0;
                            end else begin
                                n_out_ticks = r_out_ticks + 1'b1;
                            end
                            n_side = now_cool ? SIDE_COOLER : SIDE_HEATER;
                            // drive follows the phase held before this tick
                            if (now_cool) begin
                                n_cool_out = r_phase ? i_cfg.cooler_level : '0;
                                n_heat_out = '0;
                            end else begin
                                n_heat_out = r_phase ? i_cfg.heater_level : '0;
                                n_cool_out = '0;
                            end
                            // hysteresis on the active side's band
                            if (now_cool) begin
                                n_phase = r_phase ? !below_cool : above_cool;
                            end else begin
                                n_phase = r_phase ? !above_heat : below_heat;
                            end
                        end else if (r_fail_cnt > i_cfg.fail_limit) begin
                            n_heat_out = '0;
                            n_cool_out = '0;
                            n_run      = RUN_INIT;
                        end else if (r_fail_cnt != FAIL_CNT_MAX) begin
                            n_fail_cnt = r_fail_cnt + 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= RUN_OFF;
            r_side      <= SIDE_NONE;
            r_phase     <= 1'b0;
            r_out_ticks <= '0;
            r_fail_cnt  <= '0;
            r_heat_out  <= '0;
            r_cool_out  <= '0;
        end else if (i_en) begin
            r_run       <= n_run;
            r_side      <= n_side;
            r_phase     <= n_phase;
            r_out_ticks <= n_out_ticks;
            r_fail_cnt  <= n_fail_cnt;
            r_heat_out  <= n_heat_out;
            r_cool_out  <= n_cool_out;
        end
    end

    // result reports the state after the update
    always_comb begin
        o_result.heater_drive = n_heat_out;
        o_result.cooler_drive = n_cool_out;
        o_result.run_state    = n_run;
        o_result.active_side  = n_side;
        o_result.driving      = n_phase;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hcr_out_stage.sv =====
// hcr_out_stage: result register on the master side
// depends on hcr_pkg
`timescale 1ns / 1ps
`default_nettype none

module hcr_out_stage (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_load,
    output logic              o_free,
    input  hcr_pkg::t_result  i_result,
    output logic              o_valid,
    input  wire logic         i_ready,
    output hcr_pkg::t_result  o_result
);
    import hcr_pkg::*;

    logic    r_valid;
    t_result r_result;

    // can load when empty or when the held result is taken now
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== hw/rtl/heat_cool_onoff_regulator.sv =====
// heat_cool_onoff_regulator: on/off heater/cooler regulator with hysteresis
// a command waits in the input register, then its result is loaded into the result
// register driving o_m_axis_tdata; throughput: one command per cycle while the result
// stream is not stalled; the update is one compare-logic pass between those registers
// reset (synchronous, i_rst_n low): state off, side none, drives zero, fail_limit 3,
// other config and state registers zero, both pipeline stages empty
`timescale 1ns / 1ps
`default_nettype none

module heat_cool_onoff_regulator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    // command stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,  // [15:0] reading
    input  wire logic [2:0]  i_s_axis_tuser,  // [1:0] mode, [2] reading_ok
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata   // [15:0] heater_drive, [31:16] cooler_drive,
                                              // [33:32] run_state, [35:34] active_side,
                                              // [36] driving, [39:37] zero
);
    import hcr_pkg::*;

    t_cfg    cfg;
    t_item   in_item, held_item;
    t_result core_result, out_result;
    logic    held_valid, out_free, advance;

    hcr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // unpack the slave-side transaction
    always_comb begin
        in_item.mode       = i_s_axis_tuser[1:0];
        in_item.reading_ok = i_s_axis_tuser[2];
        in_item.reading    = i_s_axis_tdata;
    end

    hcr_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (advance),
        .o_item  (held_item)
    );

    // state and result register update together
    assign advance = held_valid && out_free;

    hcr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (held_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    hcr_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .o_free   (out_free),
        .i_result (core_result),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (out_result)
    );

    // pack the master-side transaction
    assign o_m_axis_tdata = {3'b000, out_result};

    // heater drive only on the heater side while not off (enable keeps the drive)
    a_heat_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && out_result.heater_drive != '0) |->
        (out_result.run_state != RUN_OFF && out_result.active_side == SIDE_HEATER))
        else $error("heater driven outside heater state");

    // cooler drive only on the cooler side while not off (enable keeps the drive)
    a_cool_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && out_result.cooler_drive != '0) |->
        (out_result.run_state != RUN_OFF && out_result.active_side == SIDE_COOLER))
        else $error("cooler driven outside cooler state");

    // a stalled result register never takes a new result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !advance)
        else $error("result overwritten while stalled");

    // an accepted command is held until it reaches the result register
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> held_valid)
        else $error("accepted command lost");

endmodule

`default_nettype wire
